FILE: rtl/tsc_pkg.sv
// Shared package for the Taylor-series sine/cosine unit: payload structs,
// fixed-point widths, control-word fields and the microcode program.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tsc_pkg;

  // default term cap and configuration register
  localparam int MAX_TERMS_DEF = 16;
  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1074;

  // port field widths
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;
  localparam int TERMS_W = 5;

  // datapath widths
  localparam int XM_W = 31;         // clamped angle magnitude, Q.28
  localparam int X2_W = 33;         // x*x rounded to Q.28
  localparam int MAG_W = 34;        // term magnitude, Q.30
  localparam int NUM_W = 39;        // rounded product plus half divisor
  localparam int RECIP_W = 39;      // divisor reciprocal
  localparam int RECIP_SHIFT = 39;  // reciprocal scaling 2^39
  localparam int SUM_W = 36;        // signed running sum, Q.30
  localparam int FRAC_SQ = 28;      // scaling of the squared angle
  localparam int A_W = 39;          // multiplier operand a
  localparam int B_W = 20;          // multiplier operand b (one chunk)
  localparam int P_W = A_W + B_W;   // product
  localparam int ACC_W = 78;        // partial-product accumulator

  // angle clamp limits and the value one in Q.30
  localparam logic [XM_W-1:0] XM_NEG_LIM = 31'h4000_0000;
  localparam logic [XM_W-1:0] XM_POS_LIM = 31'h3FFF_FFFF;
  localparam logic [MAG_W-1:0] MAG_ONE = 34'h0_4000_0000;

  // saturation bounds of the Q2.30 result
  localparam logic signed [SUM_W-1:0] VAL_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] VAL_MIN = -36'sh0_8000_0000;

  // multiplier operand selection
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_XM_LO = 3'd1;
  localparam logic [2:0] MUL_XM_HI = 3'd2;
  localparam logic [2:0] MUL_X2_LO = 3'd3;
  localparam logic [2:0] MUL_X2_HI = 3'd4;
  localparam logic [2:0] MUL_R_LO  = 3'd5;
  localparam logic [2:0] MUL_R_HI  = 3'd6;
  localparam logic [2:0] MUL_QD    = 3'd7;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD   = 2'd1;
  localparam logic [1:0] ACC_ADD_HI = 2'd2;

  // register load operations
  localparam logic [2:0] REG_NONE = 3'd0;
  localparam logic [2:0] REG_X2   = 3'd1;
  localparam logic [2:0] REG_NUM  = 3'd2;
  localparam logic [2:0] REG_Q    = 3'd3;
  localparam logic [2:0] REG_FIX  = 3'd4;
  localparam logic [2:0] REG_SUM  = 3'd5;
  localparam logic [2:0] REG_DONE = 3'd6;

  // jump conditions
  localparam logic [1:0] JMP_NONE = 2'd0;
  localparam logic [1:0] JMP_CONT = 2'd1;
  localparam logic [1:0] JMP_STOP = 2'd2;

  // program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_XM_LO  = 4'd0;
  localparam logic [PC_W-1:0] STEP_XM_HI  = 4'd1;
  localparam logic [PC_W-1:0] STEP_XM_ADD = 4'd2;
  localparam logic [PC_W-1:0] STEP_X2     = 4'd3;
  localparam logic [PC_W-1:0] STEP_T_LO   = 4'd4;
  localparam logic [PC_W-1:0] STEP_T_HI   = 4'd5;
  localparam logic [PC_W-1:0] STEP_T_ADD  = 4'd6;
  localparam logic [PC_W-1:0] STEP_NUM    = 4'd7;
  localparam logic [PC_W-1:0] STEP_R_LO   = 4'd8;
  localparam logic [PC_W-1:0] STEP_R_HI   = 4'd9;
  localparam logic [PC_W-1:0] STEP_R_ADD  = 4'd10;
  localparam logic [PC_W-1:0] STEP_QD     = 4'd11;
  localparam logic [PC_W-1:0] STEP_FIX    = 4'd12;
  localparam logic [PC_W-1:0] STEP_SUM    = 4'd13;
  localparam logic [PC_W-1:0] STEP_DONE   = 4'd14;

  typedef struct packed {
    logic                      action;
    logic signed [ANGLE_W-1:0] angle;
  } tsc_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TERMS_W-1:0]        terms_used;
    logic                      limit_hit;
  } tsc_out_t;

  typedef struct packed {
    logic [2:0]      mul_op;
    logic [1:0]      acc_op;
    logic [2:0]      reg_op;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic start;
    logic cont;
    logic out_free;
  } seq_status_t;

  localparam ctl_word_t CW_NOP = '{MUL_NONE, ACC_HOLD, REG_NONE, JMP_NONE, STEP_XM_LO};

  // microcode program: one control word per step
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = CW_NOP;
    unique case (pc)
      // square the clamped angle in two chunks
      STEP_XM_LO:  w = '{MUL_XM_LO, ACC_HOLD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_XM_HI:  w = '{MUL_XM_HI, ACC_LOAD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_XM_ADD: w = '{MUL_NONE,  ACC_ADD_HI, REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_X2:     w = '{MUL_NONE,  ACC_HOLD,   REG_X2,   JMP_STOP, STEP_DONE};
      // term times x2
      STEP_T_LO:   w = '{MUL_X2_LO, ACC_HOLD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_T_HI:   w = '{MUL_X2_HI, ACC_LOAD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_T_ADD:  w = '{MUL_NONE,  ACC_ADD_HI, REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_NUM:    w = '{MUL_NONE,  ACC_HOLD,   REG_NUM,  JMP_NONE, STEP_XM_LO};
      // divide by the divisor pair through its reciprocal
      STEP_R_LO:   w = '{MUL_R_LO,  ACC_HOLD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_R_HI:   w = '{MUL_R_HI,  ACC_LOAD,   REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_R_ADD:  w = '{MUL_NONE,  ACC_ADD_HI, REG_NONE, JMP_NONE, STEP_XM_LO};
      STEP_QD:     w = '{MUL_QD,    ACC_HOLD,   REG_Q,    JMP_NONE, STEP_XM_LO};
      STEP_FIX:    w = '{MUL_NONE,  ACC_HOLD,   REG_FIX,  JMP_NONE, STEP_XM_LO};
      // accumulate, start the next term and loop
      STEP_SUM:    w = '{MUL_X2_LO, ACC_HOLD,   REG_SUM,  JMP_CONT, STEP_T_HI};
      STEP_DONE:   w = '{MUL_NONE,  ACC_HOLD,   REG_DONE, JMP_NONE, STEP_XM_LO};
      default:     w = CW_NOP;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/tsc_useq.sv
// Microcode sequencer: step counter, busy flag, program read and jumps.
// Depends on tsc_pkg for the control word, status struct and program.
`timescale 1ns / 1ps

module tsc_useq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsc_pkg::seq_status_t    status,
  output tsc_pkg::ctl_word_t      ctl,
  output logic                    busy
);

  logic                         busy_r;
  logic                         busy_nxt;
  logic [tsc_pkg::PC_W-1:0]     pc_r;
  logic [tsc_pkg::PC_W-1:0]     pc_nxt;
  tsc_pkg::ctl_word_t           cw;
  logic                         take;

  // program read
  assign cw = tsc_pkg::ucode_rom(pc_r);

  // jump condition
  always_comb begin
    unique case (cw.jmp)
      tsc_pkg::JMP_CONT: take = status.cont;
      tsc_pkg::JMP_STOP: take = !status.cont;
      default:           take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (status.start) begin
        busy_nxt = 1'b1;
        pc_nxt   = tsc_pkg::STEP_XM_LO;
      end
    end else if (cw.reg_op == tsc_pkg::REG_DONE) begin
      // hold on the last step until the output register frees up
      if (status.out_free) begin
        busy_nxt = 1'b0;
      end
    end else if (take) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + tsc_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= tsc_pkg::STEP_XM_LO;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctl  = busy_r ? cw : tsc_pkg::CW_NOP;
  assign busy = busy_r;

endmodule

FILE: rtl/tsc_datapath.sv
// Datapath: angle clamp, shared multiplier with partial-product accumulator,
// divisor and reciprocal tables, term and sum registers, result saturation.
// Depends on tsc_pkg; driven by the control word of tsc_useq.
`timescale 1ns / 1ps

module tsc_datapath #(
  parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       start,
  input  tsc_pkg::tsc_in_t           in_data,
  input  logic [tsc_pkg::THR_W-1:0]  thr,
  input  tsc_pkg::ctl_word_t         ctl,
  output logic                       cont,
  output tsc_pkg::tsc_out_t          result
);

  localparam int M_W   = $clog2(2 * MAX_TERMS);
  localparam int TAB_N = 2 ** M_W;
  localparam int D_W   = $clog2(TAB_N * TAB_N);
  localparam int T_W   = $clog2(MAX_TERMS + 1);

  localparam int XM_W    = tsc_pkg::XM_W;
  localparam int X2_W    = tsc_pkg::X2_W;
  localparam int MAG_W   = tsc_pkg::MAG_W;
  localparam int NUM_W   = tsc_pkg::NUM_W;
  localparam int RECIP_W = tsc_pkg::RECIP_W;
  localparam int SUM_W   = tsc_pkg::SUM_W;
  localparam int A_W     = tsc_pkg::A_W;
  localparam int B_W     = tsc_pkg::B_W;
  localparam int P_W     = tsc_pkg::P_W;
  localparam int ACC_W   = tsc_pkg::ACC_W;
  localparam int FRAC_SQ = tsc_pkg::FRAC_SQ;
  localparam int ANGLE_W = tsc_pkg::ANGLE_W;

  // divisor pair m(m+1) and its reciprocal, indexed by m
  logic [D_W-1:0]     d_tab [TAB_N];
  logic [RECIP_W-1:0] r_tab [TAB_N];

  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
    if (gi == 0) begin : g_zero
      assign d_tab[gi] = '0;
      assign r_tab[gi] = '0;
    end else begin : g_ent
      localparam longint DV = longint'(gi) * longint'(gi + 1);
      localparam logic [RECIP_W-1:0] RV =
        RECIP_W'((64'd1 << tsc_pkg::RECIP_SHIFT) / DV);
      assign d_tab[gi] = D_W'(DV);
      assign r_tab[gi] = RV;
    end
  end

  logic [XM_W-1:0]         xm_r;
  logic [X2_W-1:0]         x2_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [NUM_W-1:0]        num_r;
  logic [MAG_W-1:0]        q_r;
  logic [ACC_W-1:0]        acc_r;
  logic [P_W-1:0]          prod_r;
  logic [M_W-1:0]          m_r;
  logic [T_W-1:0]          terms_r;

  logic [D_W-1:0]          d_cur;
  logic [RECIP_W-1:0]      r_cur;

  assign d_cur = d_tab[m_r];
  assign r_cur = r_tab[m_r];

  // clamp the angle to [-4, 4 - 2^-28] as sign and magnitude
  logic                    xneg;
  logic [ANGLE_W:0]        amag;
  logic [XM_W-1:0]         xm_init;
  logic [MAG_W-1:0]        mag_init;
  logic                    neg_init;
  logic signed [SUM_W-1:0] mag_init_s;

  always_comb begin
    xneg = in_data.angle[ANGLE_W-1];
    if (xneg) begin
      amag = (33'd1 << ANGLE_W) - {1'b0, in_data.angle};
      xm_init = (amag > 33'(tsc_pkg::XM_NEG_LIM)) ? tsc_pkg::XM_NEG_LIM : XM_W'(amag);
    end else begin
      amag = {1'b0, in_data.angle};
      xm_init = (amag > 33'(tsc_pkg::XM_POS_LIM)) ? tsc_pkg::XM_POS_LIM : XM_W'(amag);
    end
    if (in_data.action) begin
      mag_init = tsc_pkg::MAG_ONE;
      neg_init = 1'b0;
    end else begin
      mag_init = MAG_W'(xm_init) << 2;
      neg_init = xneg;
    end
    mag_init_s = signed'(SUM_W'(mag_init));
  end

  // shared multiplier operand selection
  logic [A_W-1:0] a_op;
  logic [B_W-1:0] b_op;
  logic [P_W-1:0] prod_nxt;

  always_comb begin
    unique case (ctl.mul_op)
      tsc_pkg::MUL_XM_LO: begin
        a_op = A_W'(xm_r);
        b_op = xm_r[B_W-1:0];
      end
      tsc_pkg::MUL_XM_HI: begin
        a_op = A_W'(xm_r);
        b_op = B_W'(xm_r[XM_W-1:B_W]);
      end
      tsc_pkg::MUL_X2_LO: begin
        a_op = A_W'(mag_r);
        b_op = x2_r[B_W-1:0];
      end
      tsc_pkg::MUL_X2_HI: begin
        a_op = A_W'(mag_r);
        b_op = B_W'(x2_r[X2_W-1:B_W]);
      end
      tsc_pkg::MUL_R_LO: begin
        a_op = A_W'(num_r);
        b_op = r_cur[B_W-1:0];
      end
      tsc_pkg::MUL_R_HI: begin
        a_op = A_W'(num_r);
        b_op = B_W'(r_cur[RECIP_W-1:B_W]);
      end
      tsc_pkg::MUL_QD: begin
        a_op = A_W'(acc_r[tsc_pkg::RECIP_SHIFT +: MAG_W]);
        b_op = B_W'(d_cur);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod_nxt = P_W'(a_op) * P_W'(b_op);
  end

  // rounding by 2^28, with half the divisor folded in for the division
  logic [D_W-1:0]   d_half;
  logic [ACC_W-1:0] rnd_sum;

  always_comb begin
    d_half  = (ctl.reg_op == tsc_pkg::REG_NUM) ? (d_cur >> 1) : '0;
    rnd_sum = acc_r + ((ACC_W'(d_half) << FRAC_SQ) + (ACC_W'(1) << (FRAC_SQ - 1)));
  end

  // quotient correction: the reciprocal estimate is low by at most one
  logic [NUM_W-1:0] rem;
  logic             bump;
  logic [MAG_W-1:0] mag_fix;

  always_comb begin
    rem     = num_r - prod_r[NUM_W-1:0];
    bump    = (rem >= NUM_W'(d_cur));
    mag_fix = q_r + MAG_W'(bump);
  end

  // multiplier and accumulator
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    unique case (ctl.acc_op)
      tsc_pkg::ACC_LOAD:   acc_r <= ACC_W'(prod_r);
      tsc_pkg::ACC_ADD_HI: acc_r <= acc_r + (ACC_W'(prod_r) << B_W);
      default:             acc_r <= acc_r;
    endcase
  end

  // term, sum and bookkeeping registers
  always_ff @(posedge clk) begin
    if (start) begin
      xm_r    <= xm_init;
      mag_r   <= mag_init;
      neg_r   <= neg_init;
      sum_r   <= neg_init ? -mag_init_s : mag_init_s;
      m_r     <= in_data.action ? M_W'(1) : M_W'(2);
      terms_r <= T_W'(1);
    end else begin
      unique case (ctl.reg_op)
        tsc_pkg::REG_X2:  x2_r  <= rnd_sum[FRAC_SQ +: X2_W];
        tsc_pkg::REG_NUM: num_r <= rnd_sum[FRAC_SQ +: NUM_W];
        tsc_pkg::REG_Q:   q_r   <= acc_r[tsc_pkg::RECIP_SHIFT +: MAG_W];
        tsc_pkg::REG_FIX: begin
          mag_r   <= mag_fix;
          m_r     <= m_r + M_W'(2);
          terms_r <= terms_r + T_W'(1);
        end
        tsc_pkg::REG_SUM: begin
          neg_r <= !neg_r;
          sum_r <= neg_r ? (sum_r + signed'(SUM_W'(mag_r)))
                         : (sum_r - signed'(SUM_W'(mag_r)));
        end
        default: ;
      endcase
    end
  end

  // loop test and result
  logic above;

  assign above = (mag_r > MAG_W'(thr));
  assign cont  = above && (terms_r < T_W'(MAX_TERMS));

  always_comb begin
    if (sum_r > tsc_pkg::VAL_MAX) begin
      result.value = tsc_pkg::VAL_MAX[tsc_pkg::VALUE_W-1:0];
    end else if (sum_r < tsc_pkg::VAL_MIN) begin
      result.value = tsc_pkg::VAL_MIN[tsc_pkg::VALUE_W-1:0];
    end else begin
      result.value = sum_r[tsc_pkg::VALUE_W-1:0];
    end
    result.terms_used = tsc_pkg::TERMS_W'(terms_r);
    result.limit_hit  = above;
  end

endmodule

FILE: rtl/taylor_sine_cosine_unit.sv
// Taylor-series sine/cosine unit, top level: handshakes, threshold register,
// output register, sequencer and datapath instances.
// Depends on tsc_pkg, tsc_useq and tsc_datapath.
//
// Usage: present an angle (signed Q4.28 radians) and an action (0 sine,
// 1 cosine) on in_data with in_valid; a transaction is taken when in_valid
// is high and in_stall low. One result transaction (Q2.30 value, terms
// used, cap flag) follows on out_data with out_valid; it is taken when
// out_stall is low, and it holds while out_stall is high.
// Each extra term is nine microcode steps on the one shared multiplier
// (two chunks for the term times x^2, two for the reciprocal, one for
// the quotient check). in_stall is high while an item is in work, so a
// new item is taken in the cycle after the previous result is loaded
// into the output register.
// While the output register holds an untaken result, the next item runs
// and waits in its last step until that register is free.
// cfg_we writes cfg_wdata into the term threshold; write only while idle.
// Reset (synchronous rst_n) clears the sequencer and out_valid and sets
// the threshold to 1074.
`timescale 1ns / 1ps

module taylor_sine_cosine_unit #(
  parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tsc_pkg::tsc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tsc_pkg::tsc_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [tsc_pkg::THR_W-1:0]  cfg_wdata
);

  logic [tsc_pkg::THR_W-1:0] thr_r;
  logic                      out_valid_r;
  tsc_pkg::tsc_out_t         out_data_r;

  tsc_pkg::seq_status_t      status;
  tsc_pkg::ctl_word_t        ctl;
  tsc_pkg::tsc_out_t         result;
  logic                      busy;
  logic                      cont;
  logic                      start;
  logic                      out_free;
  logic                      out_load;

  // handshake decode
  assign start    = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (ctl.reg_op == tsc_pkg::REG_DONE) && out_free;

  assign status.start    = start;
  assign status.cont     = cont;
  assign status.out_free = out_free;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tsc_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  tsc_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  tsc_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk     (clk),
    .start   (start),
    .in_data (in_data),
    .thr     (thr_r),
    .ctl     (ctl),
    .cont    (cont),
    .result  (result)
  );

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tsc_checker.sv
// Scoreboard for the Taylor-series sine/cosine unit: watches the input, result
// and threshold ports, predicts each result and compares it field by field.
// Depends on tsc_pkg for the payload structs and widths.
`timescale 1ns / 1ps

module tsc_checker #(
  parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  tsc_pkg::tsc_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  tsc_pkg::tsc_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [tsc_pkg::THR_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        pending
);

  logic [tsc_pkg::THR_W-1:0] threshold = tsc_pkg::THR_RESET;
  tsc_pkg::tsc_out_t         series_q[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // series sum with rounded fixed-point recurrence and final saturation
  function automatic tsc_pkg::tsc_out_t series_value(
    input tsc_pkg::tsc_in_t          item,
    input logic [tsc_pkg::THR_W-1:0] thr
  );
    logic [63:0]       xmag, x2, mag, sum, div, prod, thr64;
    logic              xneg, neg, cosine;
    int unsigned       n, terms;
    tsc_pkg::tsc_out_t r;
    cosine = item.action;
    thr64  = {33'd0, thr};
    xneg   = item.angle[tsc_pkg::ANGLE_W-1];
    xmag   = xneg ? (64'h1_0000_0000 - {32'd0, item.angle}) : {32'd0, item.angle};
    // clamp to [-4, 4 - 2^-28]
    if (xneg && xmag > 64'h4000_0000) xmag = 64'h4000_0000;
    if (!xneg && xmag > 64'h3FFF_FFFF) xmag = 64'h3FFF_FFFF;
    x2 = (xmag * xmag + (64'd1 << 27)) >> 28;
    if (cosine) begin
      mag = 64'd1 << 30;
      neg = 1'b0;
    end else begin
      mag = xmag << 2;
      neg = xneg;
    end
    sum   = neg ? (64'd0 - mag) : mag;
    n     = 1;
    terms = 1;
    while (mag > thr64 && terms < MAX_TERMS) begin
      div = cosine ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
      // split product keeps mag * x2 exact within 64 bits
      prod = (mag >> 28) * x2 + (((mag & 64'h0FFF_FFFF) * x2 + (64'd1 << 27)) >> 28);
      mag  = (prod + div / 2) / div;
      neg  = !neg;
      sum  = neg ? (sum - mag) : (sum + mag);
      n++;
      terms++;
    end
    // saturate to Q2.30
    if (sum[63]) begin
      if (sum < 64'hFFFF_FFFF_8000_0000) r.value = 32'h8000_0000;
      else r.value = sum[31:0];
    end else begin
      if (sum > 64'h7FFF_FFFF) r.value = 32'h7FFF_FFFF;
      else r.value = sum[31:0];
    end
    r.terms_used = terms[tsc_pkg::TERMS_W-1:0];
    r.limit_hit  = (mag > thr64);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  // result transactions are checked before new input transactions are queued
  always @(posedge clk) begin : monitor
    tsc_pkg::tsc_out_t want;
    if (!rst_n) begin
      threshold <= tsc_pkg::THR_RESET;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (out_valid && !out_stall) begin
        if (series_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = series_q.pop_front();
          if (out_data.value !== want.value)
            flag_field("value", want.value, out_data.value);
          if (out_data.terms_used !== want.terms_used)
            flag_field("terms_used", 32'(want.terms_used), 32'(out_data.terms_used));
          if (out_data.limit_hit !== want.limit_hit)
            flag_field("limit_hit", 32'(want.limit_hit), 32'(out_data.limit_hit));
        end
      end
      if (in_valid && !in_stall) series_q.push_back(series_value(in_data, threshold));
    end
    pending <= series_q.size();
  end

endmodule

FILE: dv/tb_taylor_sine_cosine_unit.sv
// Testbench top for the Taylor-series sine/cosine unit: clock, reset, input
// and threshold stimulus, random output stalls and the final verdict.
// Depends on tsc_pkg, taylor_sine_cosine_unit and tsc_checker.
`timescale 1ns / 1ps

module tb_taylor_sine_cosine_unit;

  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 600;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  tsc_pkg::tsc_in_t          in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  tsc_pkg::tsc_out_t         out_data;
  logic                      cfg_we = 1'b0;
  logic [tsc_pkg::THR_W-1:0] cfg_wdata = '0;

  int   mismatches;
  int   pending;
  logic steady = 1'b0;
  logic hold_request = 1'b0;

  taylor_sine_cosine_unit #(.MAX_TERMS(tsc_pkg::MAX_TERMS_DEF)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tsc_checker #(.MAX_TERMS(tsc_pkg::MAX_TERMS_DEF)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 21);
  endfunction

  // angles: mostly in range, some small, some anywhere incl. clamped
  function automatic logic [tsc_pkg::ANGLE_W-1:0] pick_angle();
    int unsigned sel;
    logic [31:0] u;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      u = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    end else if (sel < 70) begin
      u = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    end else if (sel < 75) begin
      case ($urandom_range(0, 5))
        0: u = 32'h3FFF_FFFF;
        1: u = 32'hC000_0000;
        2: u = 32'h4000_0000;
        3: u = 32'hBFFF_FFFF;
        4: u = 32'h0000_0000;
        default: u = 32'h8000_0000;
      endcase
    end else begin
      u = $urandom;
    end
    return u;
  endfunction

  // one input transaction, entered and left at a falling edge
  task automatic send_angle(input logic action,
                            input logic [tsc_pkg::ANGLE_W-1:0] angle);
    tsc_pkg::tsc_in_t item;
    item.action = action;
    item.angle  = angle;
    while (take_gap()) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom), $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [tsc_pkg::THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) send_angle(1'($urandom_range(0, 1)), pick_angle());
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= take_gap();
      end
    end
  end

  initial begin : stimulus
    logic [tsc_pkg::ANGLE_W-1:0] corner[11];
    corner = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h3FFF_FFFF,
               32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h1921_FB54, 32'hCDBC_0957, 32'h0001_0000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner angles with the reset threshold, sine and cosine
    foreach (corner[i]) begin
      send_angle(1'b0, corner[i]);
      send_angle(1'b1, corner[i]);
    end
    drain();

    // default threshold, opening with back-to-back transactions
    write_threshold(tsc_pkg::THR_RESET);
    steady <= 1'b1;
    random_phase(120);
    steady <= 1'b0;
    random_phase(PHASE_ITEMS - 120);
    drain();

    // zero threshold: items run to the term cap unless a term reaches zero
    write_threshold('0);
    random_phase(PHASE_ITEMS);
    drain();

    // mid threshold with a long output hold-off to back up the input
    write_threshold(tsc_pkg::THR_W'($urandom_range(0, 32'h0010_0000)));
    hold_request <= 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    // threshold of one in Q.30: the first term ends every cosine series and small-angle sines
    write_threshold(31'h4000_0000);
    random_phase(PHASE_ITEMS);
    drain();

    write_threshold(tsc_pkg::THR_W'($urandom_range(0, 32'h4000_0000)));
    random_phase(PHASE_ITEMS);
    drain();

    repeat (160) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/tsc_pkg.sv
rtl/tsc_useq.sv
rtl/tsc_datapath.sv
rtl/taylor_sine_cosine_unit.sv
dv/tsc_checker.sv
dv/tb_taylor_sine_cosine_unit.sv
